// ----- rtl/mmws_pkg.sv -----
// Package for the multipath maximum-window selector.
// Holds the field widths, the action and status codes and the payload types.
// No dependencies.
package mmws_pkg;

   localparam int ACTION_W = 2;
   localparam int BUNDLE_ID_W = 4;
   localparam int CONN_W = 8;
   localparam int WINDOW_W = 16;
   localparam int STATUS_W = 2;
   localparam int BUNDLE_ID_SPAN = 1 << BUNDLE_ID_W;
   localparam int CONN_SPAN = 1 << CONN_W;

   localparam logic [ACTION_W-1:0] ACTION_ADD = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_WRITE = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_SELECT = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_DUPLICATE,
      STATUS_FULL,
      STATUS_EMPTY
   } status_type;

   typedef logic [CONN_W-1:0] conn_type;
   typedef logic signed [WINDOW_W-1:0] window_type;

endpackage

// ----- rtl/mmws_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the member list, the bundle table and the window table.
// No dependencies.
module mmws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/multipath_max_window_selector.sv -----
// Multipath maximum-window selector: top level with its sequencer and tables.
// Depends on mmws_pkg and mmws_ram.
//
// A transaction is accepted at a rising edge where start is high and busy is low.
// Actions: add a connection to a bundle, write a connection's open window, or
// select the member of a bundle with the largest open window (sticky on ties).
// Every transaction gives exactly one result, shown for one cycle with rsp_valid.
//
// A window write, or an unused action code, gives its result in the cycle after
// acceptance and leaves busy low. An add or a select reads the bundle table, then
// walks the bundle's members through one shared read and compare path, one member
// per cycle. busy stays high through the bundle table read and the member walk, also
// when the bundle is empty. The result strobe comes in the cycle in which busy falls.
// The member list RAM and the window table RAM share that path, which sets the
// one-member-per-cycle pace.
//
// After reset the block clears the bundle table and window table, one entry per
// cycle, with busy high.
// The receiver cannot stall: each result is taken in the cycle it is shown.
module multipath_max_window_selector
   import mmws_pkg::*;
#(
   parameter int BUNDLES = 16,
   parameter int MAX_MEMBERS = 8,
   parameter int CONNECTIONS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [BUNDLE_ID_W-1:0] req_bundle_id,
   input  logic [CONN_W-1:0]      req_connection_id,
   input  logic signed [WINDOW_W-1:0] req_window_value,
   output logic                   rsp_valid,
   output logic [CONN_W-1:0]      rsp_chosen_connection,
   output logic signed [WINDOW_W-1:0] rsp_chosen_window,
   output logic [STATUS_W-1:0]    rsp_status
);

   localparam int BW = (BUNDLES > 1) ? $clog2(BUNDLES) : 1;
   localparam int ML_DEPTH = BUNDLES * MAX_MEMBERS;
   localparam int MLW = (ML_DEPTH > 1) ? $clog2(ML_DEPTH) : 1;
   localparam int CW = $clog2(MAX_MEMBERS + 1);
   localparam int WDEPTH = (CONNECTIONS < CONN_SPAN) ? CONNECTIONS : CONN_SPAN;
   localparam int WAW = $clog2(WDEPTH);
   localparam int SWEEP_LEN = (BUNDLES > WDEPTH) ? BUNDLES : WDEPTH;
   localparam int SWW = $clog2(SWEEP_LEN);
   localparam int BT_W = CW + CONN_W;
   localparam logic [CONN_W:0] CONN_LIMIT = (CONN_W + 1)'(WDEPTH);

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_FETCH,
      ST_SCAN
   } state_type;

   state_type        state_ff, state_in;
   logic [SWW-1:0]   sweep_ff, sweep_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [BW-1:0]    bundle_ff, bundle_in;
   conn_type         conn_ff, conn_in;
   logic [MLW-1:0]   base_ff, base_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    issue_ff, issue_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_seed_ff, s2_seed_in;
   logic             s2_inr_ff, s2_inr_in;
   conn_type         s2_conn_ff, s2_conn_in;
   logic             dup_ff, dup_in;
   logic             first_pend_ff, first_pend_in;
   conn_type         first_ff, first_in;
   window_type       best_ff, best_in;
   conn_type         chosen_ff, chosen_in;
   logic             rsp_valid_ff, rsp_valid_in;
   conn_type         rsp_conn_ff, rsp_conn_in;
   window_type       rsp_window_ff, rsp_window_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic [BW-1:0]    bundle_map [BUNDLE_ID_SPAN];

   logic             ml_wr_en, ml_rd_en;
   logic [MLW-1:0]   ml_wr_addr, ml_rd_addr;
   conn_type         ml_wr_data, ml_rd_data;

   logic             bt_wr_en, bt_rd_en;
   logic [BW-1:0]    bt_wr_addr, bt_rd_addr;
   logic [BT_W-1:0]  bt_wr_data, bt_rd_data;

   logic             wt_wr_en, wt_rd_en;
   logic [WAW-1:0]   wt_wr_addr, wt_rd_addr;
   logic [WINDOW_W-1:0] wt_wr_data, wt_rd_data;

   window_type       s2_window;
   logic             scan_done;

   for (genvar v = 0; v < BUNDLE_ID_SPAN; v++) begin : g_bundle_map
      assign bundle_map[v] = BW'(v % BUNDLES);
   end

   mmws_ram #(.WIDTH(CONN_W), .DEPTH(ML_DEPTH)) u_member_ram (
      .clock   (clock),
      .wr_en   (ml_wr_en),
      .wr_addr (ml_wr_addr),
      .wr_data (ml_wr_data),
      .rd_en   (ml_rd_en),
      .rd_addr (ml_rd_addr),
      .rd_data (ml_rd_data)
   );

   mmws_ram #(.WIDTH(BT_W), .DEPTH(BUNDLES)) u_bundle_ram (
      .clock   (clock),
      .wr_en   (bt_wr_en),
      .wr_addr (bt_wr_addr),
      .wr_data (bt_wr_data),
      .rd_en   (bt_rd_en),
      .rd_addr (bt_rd_addr),
      .rd_data (bt_rd_data)
   );

   mmws_ram #(.WIDTH(WINDOW_W), .DEPTH(WDEPTH)) u_window_ram (
      .clock   (clock),
      .wr_en   (wt_wr_en),
      .wr_addr (wt_wr_addr),
      .wr_data (wt_wr_data),
      .rd_en   (wt_rd_en),
      .rd_addr (wt_rd_addr),
      .rd_data (wt_rd_data)
   );

   assign s2_window = s2_inr_ff ? window_type'(wt_rd_data) : '0;
   assign scan_done = (issue_ff == count_ff) && !s1_valid_ff && !s2_valid_ff;

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      act_in = act_ff;
      bundle_in = bundle_ff;
      conn_in = conn_ff;
      base_in = base_ff;
      count_in = count_ff;
      issue_in = issue_ff;
      s1_valid_in = 1'b0;
      s2_valid_in = 1'b0;
      s2_seed_in = 1'b0;
      s2_inr_in = s2_inr_ff;
      s2_conn_in = s2_conn_ff;
      dup_in = dup_ff;
      first_pend_in = first_pend_ff;
      first_in = first_ff;
      best_in = best_ff;
      chosen_in = chosen_ff;
      rsp_valid_in = 1'b0;
      rsp_conn_in = '0;
      rsp_window_in = '0;
      rsp_status_in = STATUS_OK;

      ml_wr_en = 1'b0;
      ml_wr_addr = base_ff + MLW'(count_ff);
      ml_wr_data = conn_ff;
      ml_rd_en = 1'b0;
      ml_rd_addr = base_ff + MLW'(issue_ff);
      bt_wr_en = 1'b0;
      bt_wr_addr = bundle_ff;
      bt_wr_data = '0;
      bt_rd_en = 1'b0;
      bt_rd_addr = bundle_map[req_bundle_id];
      wt_wr_en = 1'b0;
      wt_wr_addr = req_connection_id[WAW-1:0];
      wt_wr_data = req_window_value;
      wt_rd_en = 1'b0;
      wt_rd_addr = ml_rd_data[WAW-1:0];

      case (state_ff)
         ST_SWEEP: begin
            bt_wr_en = (32'(sweep_ff) < BUNDLES);
            bt_wr_addr = sweep_ff[BW-1:0];
            wt_wr_en = (32'(sweep_ff) < WDEPTH);
            wt_wr_addr = sweep_ff[WAW-1:0];
            wt_wr_data = '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWW'(SWEEP_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               act_in = req_action;
               bundle_in = bundle_map[req_bundle_id];
               conn_in = req_connection_id;
               base_in = MLW'(bundle_map[req_bundle_id] * MAX_MEMBERS);
               if (req_action == ACTION_ADD || req_action == ACTION_SELECT) begin
                  bt_rd_en = 1'b1;
                  state_in = ST_FETCH;
               end else begin
                  wt_wr_en = (req_action == ACTION_WRITE) &&
                             ({1'b0, req_connection_id} < CONN_LIMIT);
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            count_in = bt_rd_data[BT_W-1:CONN_W];
            issue_in = '0;
            dup_in = 1'b0;
            first_pend_in = 1'b1;
            first_in = conn_ff;
            if (act_ff == ACTION_SELECT && bt_rd_data[BT_W-1:CONN_W] != '0) begin
               wt_rd_en = 1'b1;
               wt_rd_addr = bt_rd_data[WAW-1:0];
               s2_valid_in = 1'b1;
               s2_seed_in = 1'b1;
               s2_conn_in = bt_rd_data[CONN_W-1:0];
               s2_inr_in = {1'b0, bt_rd_data[CONN_W-1:0]} < CONN_LIMIT;
            end
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (issue_ff != count_ff) begin
               ml_rd_en = 1'b1;
               issue_in = issue_ff + 1'b1;
               s1_valid_in = 1'b1;
            end
            if (s1_valid_ff) begin
               if (act_ff == ACTION_ADD) begin
                  if (ml_rd_data == conn_ff) begin
                     dup_in = 1'b1;
                  end
                  if (first_pend_ff) begin
                     first_in = ml_rd_data;
                     first_pend_in = 1'b0;
                  end
               end else begin
                  wt_rd_en = 1'b1;
                  s2_valid_in = 1'b1;
                  s2_conn_in = ml_rd_data;
                  s2_inr_in = {1'b0, ml_rd_data} < CONN_LIMIT;
               end
            end
            if (s2_valid_ff && (s2_seed_ff || s2_window > best_ff)) begin
               best_in = s2_window;
               chosen_in = s2_conn_ff;
            end
            if (scan_done) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
               if (act_ff == ACTION_ADD) begin
                  if (dup_ff) begin
                     rsp_status_in = STATUS_DUPLICATE;
                  end else if (count_ff == CW'(MAX_MEMBERS)) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     ml_wr_en = 1'b1;
                     bt_wr_en = 1'b1;
                     bt_wr_data = {count_ff + 1'b1, first_ff};
                  end
               end else if (count_ff == '0) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  bt_wr_en = 1'b1;
                  bt_wr_data = {count_ff, chosen_ff};
                  rsp_conn_in = chosen_ff;
                  rsp_window_in = best_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         sweep_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_seed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s2_seed_ff <= s2_seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff <= act_in;
      bundle_ff <= bundle_in;
      conn_ff <= conn_in;
      base_ff <= base_in;
      count_ff <= count_in;
      issue_ff <= issue_in;
      s2_inr_ff <= s2_inr_in;
      s2_conn_ff <= s2_conn_in;
      dup_ff <= dup_in;
      first_pend_ff <= first_pend_in;
      first_ff <= first_in;
      best_ff <= best_in;
      chosen_ff <= chosen_in;
      rsp_conn_ff <= rsp_conn_in;
      rsp_window_ff <= rsp_window_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_chosen_connection = rsp_conn_ff;
   assign rsp_chosen_window = rsp_window_ff;
   assign rsp_status = rsp_status_ff;

endmodule
